/* hw/rtl/bwa_pkg.sv */
// bwa_pkg: widths, window sizes and divider request type of the bitrate window averager
// used by bwa_div, bitrate_window_averager, bwa_chk and the testbench; depends on nothing
`default_nettype none

package bwa_pkg;

  localparam int unsigned SHORT_WINDOW = 8;
  localparam int unsigned LONG_WINDOW  = 240;

  localparam int unsigned BYTES_W = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned KBPS_W  = 20;
  localparam int unsigned AVG_W   = 19;

  // bytes * 8000 + elapsed / 2 stays below 2^31, and so do both sums
  localparam int unsigned DIV_W   = 31;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  localparam int unsigned RATE_SCALE   = 8000;
  localparam int unsigned SCALE_W      = 13;
  localparam int unsigned KBIT         = 1000;

  localparam int unsigned SHORT_IDX_W = (SHORT_WINDOW > 1) ? $clog2(SHORT_WINDOW) : 1;
  localparam int unsigned LONG_IDX_W  = $clog2(LONG_WINDOW);
  localparam int unsigned SHORT_SUM_W = $clog2(SHORT_WINDOW) + KBPS_W;
  localparam int unsigned LONG_SUM_W  = $clog2(LONG_WINDOW) + KBPS_W;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } bwa_div_req_t;

endpackage

`default_nettype wire

/* hw/rtl/bwa_div.sv */
// bwa_div: restoring divider, one quotient bit per cycle, a DIV_W-bit quotient per division
// depends on bwa_pkg
`default_nettype none

module bwa_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bwa_pkg::bwa_div_req_t       req_i,
  output logic [bwa_pkg::DIV_W-1:0]        quo_o,
  output logic                             done_o
);
  import bwa_pkg::*;

  logic [DIV_W-1:0]     rem_q, quo_q, den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [DIV_W:0]       trial, diff;
  logic                 ge;

  // shift the next numerator bit into the partial remainder
  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_CNT_W'(DIV_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

/* hw/rtl/bitrate_window_averager.sv */
// bitrate_window_averager: measures kbit/s from byte counts and timestamps and keeps
// a short and a long moving average; depends on bwa_pkg and bwa_div
//
//  channel  | dir | tdata (low bit up)                 | tuser
//  s_axis   | in  | byte_count[15:0], now_ms[31:0]     | -
//  m_axis   | out | short_avg_kbps[18:0], long_avg_kbps[18:0], pad | updated
//
// one transaction in gives one transaction out; a zero byte count skips the divider
// a sample runs the one shared bit-serial divider for rate, kbit scaling,
// short average and long average in turn
// the long window lives in a one-port memory with registered read; unwritten slots
// are read while filling but count as zero, so no clearing pass follows reset
// the next item is taken while a result still waits in the output register
`default_nettype none

module bitrate_window_averager (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // byte_count[15:0], now_ms[47:16]
  input  wire logic [bwa_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // short_avg_kbps[18:0], long_avg_kbps[37:19], zero pad [39:38]
  output logic [bwa_pkg::OUT_DATA_W-1:0]         m_axis_tdata_o,
  // updated[0]
  output logic [0:0]                             m_axis_tuser_o
);
  import bwa_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_ELAPSED = 4'd1;
  localparam logic [3:0] ST_RATE    = 4'd2;
  localparam logic [3:0] ST_RATE_W  = 4'd3;
  localparam logic [3:0] ST_KBPS_W  = 4'd4;
  localparam logic [3:0] ST_SUM     = 4'd5;
  localparam logic [3:0] ST_SHORT_W = 4'd6;
  localparam logic [3:0] ST_LONG_W  = 4'd7;
  localparam logic [3:0] ST_OUT     = 4'd8;

  logic [3:0] state_q, state_d;

  logic [BYTES_W-1:0] bytes_q;
  logic [TIME_W-1:0]  now_q, last_time_q;
  logic [DIV_W-1:0]   elapsed_q;
  logic [KBPS_W-1:0]  kbps_q;

  logic [KBPS_W-1:0]      short_ring_q [SHORT_WINDOW];
  logic [SHORT_SUM_W-1:0] short_sum_q;
  logic [SHORT_IDX_W-1:0] short_slot_q;
  logic                   short_fill_q;

  logic [KBPS_W-1:0]      long_mem [LONG_WINDOW];
  logic [KBPS_W-1:0]      long_rd_q;
  logic [LONG_SUM_W-1:0]  long_sum_q;
  logic [LONG_IDX_W-1:0]  long_slot_q;
  logic                   long_fill_q;
  logic [LONG_IDX_W:0]    long_den_q;

  logic [AVG_W-1:0] res_s_q, res_l_q;
  logic             res_upd_q;

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_upd_q;

  bwa_div_req_t     div_req;
  logic [DIV_W-1:0] div_quo;
  logic             div_done;

  logic                        in_fire, out_free;
  logic [TIME_W-1:0]           diff;
  logic [BYTES_W+SCALE_W-1:0]  bits_scaled;
  logic [KBPS_W-1:0]           short_old, long_old;
  logic [SHORT_SUM_W-1:0]      short_sum_d;
  logic [LONG_SUM_W-1:0]       long_sum_d;
  logic                        short_last, long_last;

  bwa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .quo_o  (div_quo),
    .done_o (div_done)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    diff        = now_q - last_time_q;
    bits_scaled = (BYTES_W+SCALE_W)'(bytes_q) * (BYTES_W+SCALE_W)'(RATE_SCALE);
    // slots beyond the fill point were never written and count as zero
    short_old   = short_fill_q ? '0 : short_ring_q[short_slot_q];
    long_old    = long_fill_q ? '0 : long_rd_q;
    short_sum_d = short_sum_q - SHORT_SUM_W'(short_old) + SHORT_SUM_W'(kbps_q);
    long_sum_d  = long_sum_q - LONG_SUM_W'(long_old) + LONG_SUM_W'(kbps_q);
    short_last  = (short_slot_q == SHORT_IDX_W'(SHORT_WINDOW - 1));
    long_last   = (long_slot_q == LONG_IDX_W'(LONG_WINDOW - 1));
  end

  // next state and divider requests
  always_comb begin
    state_d       = state_q;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (s_axis_tdata_i[BYTES_W-1:0] == '0) ? ST_OUT : ST_ELAPSED;
        end
      end
      ST_ELAPSED: state_d = ST_RATE;
      ST_RATE: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_W'(bits_scaled) + (elapsed_q >> 1);
        div_req.den   = elapsed_q;
        state_d       = ST_RATE_W;
      end
      ST_RATE_W: begin
        if (div_done) begin
          div_req.start = 1'b1;
          div_req.num   = div_quo;
          div_req.den   = DIV_W'(KBIT);
          state_d       = ST_KBPS_W;
        end
      end
      ST_KBPS_W: begin
        if (div_done) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_W'(short_sum_d);
        div_req.den   = short_fill_q ? DIV_W'(short_slot_q) + 1'b1 : DIV_W'(SHORT_WINDOW);
        state_d       = ST_SHORT_W;
      end
      ST_SHORT_W: begin
        if (div_done) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_W'(long_sum_q);
          div_req.den   = DIV_W'(long_den_q);
          state_d       = ST_LONG_W;
        end
      end
      ST_LONG_W: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      last_time_q  <= '0;
      short_sum_q  <= '0;
      short_slot_q <= '0;
      short_fill_q <= 1'b1;
      long_sum_q   <= '0;
      long_slot_q  <= '0;
      long_fill_q  <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SUM) begin
        last_time_q  <= now_q;
        short_sum_q  <= short_sum_d;
        long_sum_q   <= long_sum_d;
        short_slot_q <= short_last ? '0 : short_slot_q + 1'b1;
        long_slot_q  <= long_last ? '0 : long_slot_q + 1'b1;
        if (short_last) begin
          short_fill_q <= 1'b0;
        end
        if (long_last) begin
          long_fill_q <= 1'b0;
        end
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          bytes_q   <= s_axis_tdata_i[BYTES_W-1:0];
          now_q     <= s_axis_tdata_i[BYTES_W +: TIME_W];
          res_s_q   <= '0;
          res_l_q   <= '0;
          res_upd_q <= 1'b0;
        end
      end
      ST_ELAPSED: begin
        // not positive as a signed value means one millisecond
        elapsed_q <= (diff == '0 || diff[TIME_W-1]) ? DIV_W'(1) : diff[DIV_W-1:0];
      end
      ST_KBPS_W: begin
        if (div_done) begin
          kbps_q <= div_quo[KBPS_W-1:0];
        end
      end
      ST_SUM: begin
        short_ring_q[short_slot_q] <= kbps_q;
        long_den_q <= long_fill_q ? (LONG_IDX_W+1)'(long_slot_q) + 1'b1
                                  : (LONG_IDX_W+1)'(LONG_WINDOW);
      end
      ST_SHORT_W: begin
        if (div_done) begin
          res_s_q <= div_quo[AVG_W-1:0];
        end
      end
      ST_LONG_W: begin
        if (div_done) begin
          res_l_q   <= div_quo[AVG_W-1:0];
          res_upd_q <= 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_data_q <= OUT_DATA_W'({res_l_q, res_s_q});
          out_upd_q  <= res_upd_q;
        end
      end
      default: ;
    endcase
  end

  // long window memory: read while the kbit division runs, write in the sum step
  always_ff @(posedge clk_i) begin
    if (state_q == ST_KBPS_W) begin
      long_rd_q <= long_mem[long_slot_q];
    end
    if (state_q == ST_SUM) begin
      long_mem[long_slot_q] <= kbps_q;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tuser_o[0] = out_upd_q;

endmodule

`default_nettype wire

/* hw/rtl/bwa_chk.sv */
// bwa_chk: port-level checks of bitrate_window_averager, bound to the top level
// depends on bwa_pkg
`default_nettype none

module bwa_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid_i,
  input wire logic                          s_axis_tready_o,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i,
  input wire logic [bwa_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input wire logic [0:0]                    m_axis_tuser_o
);
  import bwa_pkg::*;

  logic in_fire;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // a result without a sample carries zero averages
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("non-zero averages without update");

  // one item at a time: intake closes right after a transaction
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("second item taken while busy");

  // no result can appear in the cycle after intake
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("result before the work could finish");

  // padding above the long average stays clear
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OUT_DATA_W-1:2*AVG_W] == '0)
    else $error("tdata padding not zero");

endmodule

bind bitrate_window_averager bwa_chk u_bwa_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

/* tb/bitrate_window_averager_tb.sv */
// bitrate_window_averager_tb: self-checking testbench for the bitrate window averager
// streams byte counts and timestamps in, predicts short and long kbit/s averages, checks
// every output transaction; depends on bwa_pkg and the bitrate_window_averager rtl
`default_nettype none

module bitrate_window_averager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bwa_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [AVG_W-1:0] short_avg;
    logic [AVG_W-1:0] long_avg;
    logic             updated;
  } avg_result_t;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_data  = '0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;
  logic [0:0]            m_user;

  bitrate_window_averager u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always #5 clk_i = ~clk_i;

  // items waiting to be driven and averages waiting to come out
  logic [IN_DATA_W-1:0] pending_items [$];
  avg_result_t          avg_queue [$];

  // predictor state: window 0 is the short one, window 1 the long one
  logic [TIME_W-1:0] last_stamp;
  logic [KBPS_W-1:0] win_ring [2][LONG_WINDOW];
  int unsigned       win_size [2];
  int unsigned       win_sum [2];
  int unsigned       win_slot [2];
  bit                win_filling [2];

  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned samples_taken;
  int unsigned clamped_steps;
  int unsigned long_wraps;
  int unsigned mismatches;

  function automatic avg_result_t predict_averages(logic [BYTES_W-1:0] count,
                                                   logic [TIME_W-1:0] now);
    avg_result_t       res;
    logic [TIME_W-1:0] diff;
    longint unsigned   elapsed;
    longint unsigned   bit_rate;
    longint unsigned   wide_count;
    logic [KBPS_W-1:0] kbps;
    int unsigned       idx;
    int unsigned       avg [2];
    res = '0;
    if (count == '0) begin
      return res;
    end
    diff = now - last_stamp;
    if (diff == '0 || diff[TIME_W-1]) begin
      elapsed = 1;
      clamped_steps++;
    end else begin
      elapsed = diff;
    end
    wide_count = count;
    bit_rate = (wide_count * 8000 + elapsed / 2) / elapsed;
    kbps = KBPS_W'(bit_rate / 1000);
    for (int w = 0; w < 2; w++) begin
      idx = win_slot[w];
      if (idx >= win_size[w]) idx = 0;
      win_sum[w] = win_sum[w] - win_ring[w][idx] + kbps;
      win_ring[w][idx] = kbps;
      if (win_filling[w]) begin
        if (idx == win_size[w] - 1) win_filling[w] = 1'b0;
        avg[w] = win_sum[w] / (idx + 1);
      end else begin
        avg[w] = win_sum[w] / win_size[w];
      end
      idx++;
      win_slot[w] = (idx == win_size[w]) ? 0 : idx;
      if (w == 1 && win_slot[w] == 0) long_wraps++;
    end
    last_stamp = now;
    samples_taken++;
    res.short_avg = avg[0][AVG_W-1:0];
    res.long_avg  = avg[1][AVG_W-1:0];
    res.updated   = 1'b1;
    return res;
  endfunction

  task automatic add_item(logic [BYTES_W-1:0] count, logic [TIME_W-1:0] now);
    pending_items.push_back({now, count});
  endtask

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d averages still expected",
               cycle_count, avg_queue.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // sender: bursts of random length separated by random gaps
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid    <= 1'b0;
      s_data     <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (s_valid && s_ready) begin
        avg_queue.push_back(predict_averages(s_data[BYTES_W-1:0], s_data[BYTES_W +: TIME_W]));
        items_sent++;
      end
      if (!s_valid || s_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          s_data  <= pending_items.pop_front();
          s_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // a third of the bursts follow on with no gap at all
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
            burst_left = $urandom_range(0, 15);
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: cycles through always ready, random stalls and one-in-four ready
  int unsigned rcv_tick;
  int unsigned stall_left;
  avg_result_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready    <= 1'b0;
      rcv_tick   = 0;
      stall_left = 0;
    end else begin
      if (m_valid && m_ready) begin
        results_checked++;
        if (avg_queue.size() == 0) begin
          note_mismatch($sformatf("unexpected transaction tdata=%h tuser=%b", m_data, m_user));
        end else begin
          want = avg_queue.pop_front();
          if (m_data[AVG_W-1:0] !== want.short_avg)
            note_mismatch($sformatf("short_avg_kbps expected %0d got %0d",
                                    want.short_avg, m_data[AVG_W-1:0]));
          if (m_data[AVG_W +: AVG_W] !== want.long_avg)
            note_mismatch($sformatf("long_avg_kbps expected %0d got %0d",
                                    want.long_avg, m_data[AVG_W +: AVG_W]));
          if (m_data[OUT_DATA_W-1:2*AVG_W] !== '0)
            note_mismatch($sformatf("tdata pad expected 0 got %b",
                                    m_data[OUT_DATA_W-1:2*AVG_W]));
          if (m_user[0] !== want.updated)
            note_mismatch($sformatf("updated expected %b got %b", want.updated, m_user[0]));
        end
      end
      rcv_tick++;
      if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else begin
        case ((rcv_tick / 512) % 3)
          0: m_ready <= 1'b1;
          1: begin
            if ($urandom_range(0, 3) == 0) begin
              stall_left = $urandom_range(0, 39);
              m_ready <= 1'b0;
            end else begin
              m_ready <= 1'b1;
            end
          end
          default: m_ready <= (rcv_tick % 4 == 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned       pick;
    logic [BYTES_W-1:0] count;
    logic [TIME_W-1:0]  clock_ms;

    last_stamp = '0;
    win_size[0] = SHORT_WINDOW;
    win_size[1] = LONG_WINDOW;
    for (int w = 0; w < 2; w++) begin
      win_sum[w]     = 0;
      win_slot[w]    = 0;
      win_filling[w] = 1'b1;
      for (int i = 0; i < LONG_WINDOW; i++) win_ring[w][i] = '0;
    end

    // directed: zero counts, equal, backward and widest steps, rate extremes,
    // rounding across a kbit boundary, and enough samples to wrap the short window
    add_item(16'd0, 32'd0);
    add_item(16'd1, 32'd0);
    add_item(16'hFFFF, 32'd1);
    add_item(16'hFFFF, 32'd1);
    add_item(16'd0, 32'hFFFF_FFFF);
    add_item(16'd1000, 32'd101);
    add_item(16'd3, 32'h8000_0065);
    add_item(16'd5, 32'h8000_0064);
    add_item(16'd1, 32'h0000_0063);
    add_item(16'd1999, 32'd16099);
    add_item(16'd1999, 32'd32100);
    add_item(16'h5555, 32'd32200);
    add_item(16'hAAAA, 32'd32300);
    add_item(16'd32768, 32'd32301);
    add_item(16'd0, 32'h5555_AAAA);
    add_item(16'd125, 32'd32302);
    clock_ms = 32'd32302;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        add_item('0, $urandom());
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55)      count = BYTES_W'($urandom_range(1, 2000));
        else if (pick < 90) count = BYTES_W'($urandom_range(1, 65535));
        else                count = 16'hFFFF;
        pick = $urandom_range(0, 99);
        if (pick < 55)      clock_ms = clock_ms + $urandom_range(80, 120);
        else if (pick < 70) clock_ms = clock_ms + $urandom_range(1, 10);
        else if (pick < 76) clock_ms = clock_ms;
        else if (pick < 82) clock_ms = clock_ms - $urandom_range(1, 1000);
        else if (pick < 88) clock_ms = $urandom();
        else                clock_ms = clock_ms + $urandom_range(1000, 200000);
        add_item(count, clock_ms);
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || s_valid) @(posedge clk_i);
    while (avg_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d transactions in, %0d out checked: %0d rate samples, %0d clamped steps",
             items_sent, results_checked, samples_taken, clamped_steps);
    $display("long window wrapped %0d times, %0d mismatches in %0d cycles",
             long_wraps, mismatches, cycle_count);
    if (mismatches == 0 && avg_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/bwa_pkg.sv
hw/rtl/bwa_div.sv
hw/rtl/bitrate_window_averager.sv
hw/rtl/bwa_chk.sv
tb/bitrate_window_averager_tb.sv
